@@ rtl/core/cve_pkg.sv @@
// ----------------------------------------------------------------------------
// cve_pkg
// Shared types and constants of the 3x3 vertical edge convolution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cve_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_SIZE       = 3;
  localparam int COL_W          = $clog2(MAX_WIDTH);
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int PIX_W          = 8;
  localparam int WIDTH_REG_W    = 11;
  localparam int HEIGHT_REG_W   = 13;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  // Truncating divide by nine: floor(x * DIV9_MUL / 2**DIV9_SHIFT) for x <= 765.
  localparam int SUM_W          = PIX_W + 2;
  localparam int DIV9_MUL       = 1821;
  localparam int DIV9_MUL_W     = 11;
  localparam int DIV9_SHIFT     = 14;
  localparam int PROD_W         = SUM_W + DIV9_MUL_W;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic rd_en;
    col_t rd_addr;
    logic wr_en;
    col_t wr_addr;
    pix_t wr_pix;
  } lb_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/cve_stream_if.sv @@
// ----------------------------------------------------------------------------
// cve_pixel_if / cve_result_if
// Valid/ready channels for incoming pixels and outgoing filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cve_pixel_if;
  import cve_pkg::*;
  logic valid;
  logic ready;
  pix_t gray_level;
  logic frame_start;

  modport source (output valid, output gray_level, output frame_start, input ready);
  modport sink (input valid, input gray_level, input frame_start, output ready);
endinterface

interface cve_result_if;
  import cve_pkg::*;
  logic valid;
  logic ready;
  pix_t filtered_value;
  col_t out_column;
  row_t out_row;
  logic frame_last;

  modport source (output valid, output filtered_value, output out_column, output out_row,
                  output frame_last, input ready);
  modport sink (input valid, input filtered_value, input out_column, input out_row,
                input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cve_line_buffer.sv @@
// ----------------------------------------------------------------------------
// cve_line_buffer
// Two row memories with registered read and same-address write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module cve_line_buffer
  import cve_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lb_ctrl_t ctrl,
  output logic [PIX_W-1:0] upper_pix,
  output logic [PIX_W-1:0] middle_pix
);

  pix_t mem_upper  [MAX_WIDTH];
  pix_t mem_middle [MAX_WIDTH];

  pix_t rd_upper;
  pix_t rd_middle;
  logic byp;
  pix_t byp_upper;
  pix_t byp_middle;

  assign middle_pix = byp ? byp_middle : rd_middle;
  assign upper_pix  = byp ? byp_upper  : rd_upper;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem_middle[ctrl.wr_addr] <= ctrl.wr_pix;
    end
    if (ctrl.rd_en) begin
      rd_middle <= mem_middle[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem_upper[ctrl.wr_addr] <= middle_pix;
    end
    if (ctrl.rd_en) begin
      rd_upper <= mem_upper[ctrl.rd_addr];
    end
  end

  // forward the write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (ctrl.rd_en) begin
      byp <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      byp_middle <= ctrl.wr_pix;
      byp_upper  <= middle_pix;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/conv3x3_vertical_edge_unit.sv @@
// ----------------------------------------------------------------------------
// conv3x3_vertical_edge_unit
// 3x3 vertical edge filter (+1 / 0 / -1 columns, sum / 9) over a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready channel of raster-order gray levels; frame_start
//            marks row 0, column 0 of a frame.
//   result : valid/ready channel, one transaction per interior window, tagged
//            with the window's top-left column and row; frame_last marks the
//            final result of the frame.
//   APB    : image_width at 0x0, image_height at 0x4; write only while idle.
// Throughput: one pixel per cycle, sustained while results are taken.
// Path: a pixel transaction is registered into the read stage together with
//   the registered row memory read; its result goes to the result register.
// Reset: counters start at row 0, column 0, the window clears, sizes return
//   to 640 x 480; row memory contents are not cleared.
// Stall: a held result keeps its payload; an empty read stage takes one more
//   pixel, after which pixel.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_vertical_edge_unit
  import cve_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  cve_pixel_if.sink               pixel,
  cve_result_if.source            result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  reg_index_t              reg_index;

  col_t col_count;
  row_t row_count;

  logic s1_valid;
  pix_t s1_pix;
  col_t s1_col;
  row_t s1_row;
  logic s1_produce;
  logic s1_last;

  pix_t win_mid   [3];
  pix_t win_right [3];

  lb_ctrl_t lb_ctrl;
  pix_t     upper_pix;
  pix_t     middle_pix;

  logic accept;
  logic s1_adv;

  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  col_t                    col_cur;
  row_t                    row_cur;
  logic [WIDTH_REG_W-1:0]  col_inc;
  logic [HEIGHT_REG_W-1:0] row_inc;
  logic                    wrap_col;
  logic                    wrap_row;

  logic [SUM_W-1:0]  sum_pos;
  logic [SUM_W-1:0]  sum_neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  pix_t              quot;
  pix_t              filt;

  // configuration port
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(WIDTH_RESET);
      image_height <= HEIGHT_REG_W'(HEIGHT_RESET);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_IMAGE_WIDTH:  prdata = {{(PDATA_W-WIDTH_REG_W){1'b0}}, image_width};
      REG_IMAGE_HEIGHT: prdata = {{(PDATA_W-HEIGHT_REG_W){1'b0}}, image_height};
      default:          prdata = '0;
    endcase
  end

  // handshake
  assign s1_adv      = s1_valid && (!result.valid || result.ready);
  assign pixel.ready = !s1_valid || s1_adv;
  assign accept      = pixel.valid && pixel.ready;

  // position counters
  always_comb begin
    if (image_width < WIDTH_REG_W'(MIN_SIZE)) begin
      eff_w = WIDTH_REG_W'(MIN_SIZE);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height < HEIGHT_REG_W'(MIN_SIZE)) begin
      eff_h = HEIGHT_REG_W'(MIN_SIZE);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign col_cur  = pixel.frame_start ? '0 : col_count;
  assign row_cur  = pixel.frame_start ? '0 : row_count;
  assign col_inc  = {{(WIDTH_REG_W-COL_W){1'b0}}, col_cur} + 1'b1;
  assign row_inc  = {{(HEIGHT_REG_W-ROW_W){1'b0}}, row_cur} + 1'b1;
  assign wrap_col = col_inc >= eff_w;
  assign wrap_row = row_inc >= eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (wrap_col) begin
        col_count <= '0;
        row_count <= wrap_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count <= col_inc[COL_W-1:0];
        row_count <= row_cur;
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix     <= pixel.gray_level;
      s1_col     <= col_cur;
      s1_row     <= row_cur;
      s1_produce <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      s1_last    <= wrap_row && wrap_col;
    end
  end

  always_comb begin
    lb_ctrl.rd_en   = accept;
    lb_ctrl.rd_addr = col_cur;
    lb_ctrl.wr_en   = s1_adv;
    lb_ctrl.wr_addr = s1_col;
    lb_ctrl.wr_pix  = s1_pix;
  end

  cve_line_buffer u_line_buffer (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lb_ctrl),
    .upper_pix  (upper_pix),
    .middle_pix (middle_pix)
  );

  // window and kernel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win_mid[r]   <= '0;
        win_right[r] <= '0;
      end
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_mid[r] <= win_right[r];
      end
      win_right[0] <= upper_pix;
      win_right[1] <= middle_pix;
      win_right[2] <= s1_pix;
    end
  end

  always_comb begin
    sum_pos = SUM_W'(win_mid[0]) + SUM_W'(win_mid[1]) + SUM_W'(win_mid[2]);
    sum_neg = SUM_W'(upper_pix) + SUM_W'(middle_pix) + SUM_W'(s1_pix);
    mag     = (sum_pos >= sum_neg) ? (sum_pos - sum_neg) : (sum_neg - sum_pos);
    prod    = PROD_W'(mag) * PROD_W'(DIV9_MUL);
    quot    = PIX_W'(prod >> DIV9_SHIFT);
    filt    = (sum_pos >= sum_neg) ? quot : (~quot + 1'b1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= s1_produce;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.filtered_value <= filt;
      result.out_column     <= s1_col - COL_W'(2);
      result.out_row        <= s1_row - ROW_W'(2);
      result.frame_last     <= s1_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cve_checker.sv @@
// ----------------------------------------------------------------------------
// cve_checker
// Port-level assertions for conv3x3_vertical_edge_unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cve_checker
  import cve_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  cve_pixel_if.sink    pixel,
  cve_result_if.source result,
  input wire logic pready
);

  // a stalled result transaction stays and keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.filtered_value))
    else $error("result transaction dropped or changed while stalled");

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  // magnitude of sum / 9 never exceeds 85
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.filtered_value <= 8'd85) || (result.filtered_value >= 8'd171))
    else $error("filtered value outside kernel range");

  // pixel side always free while no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result.valid && $past(!result.valid) && !$past(rst) |-> pixel.ready)
    else $error("pixel channel stalled with empty output");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind conv3x3_vertical_edge_unit cve_checker u_cve_checker (
  .clk    (clk),
  .rst    (rst),
  .pixel  (pixel),
  .result (result),
  .pready (pready)
);

`default_nettype wire
